// ===== design/ttlbf_pkg.sv =====
// Shared types and constants for the TTL-bucketed FIFO cache policy block.
// Used by ttlbf_core and ttl_bucket_fifo_cache_policy_top; depends on nothing.
`timescale 1ns / 1ps
package ttlbf_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int BUCKETS_DEF = 1024;

	localparam logic [23:0] CAPACITY_RST = 24'd65536;
	localparam logic [15:0] LIFETIME_RST = 16'd3600;

	localparam logic [1:0] OUT_MISS   = 2'd0;
	localparam logic [1:0] OUT_HIT    = 2'd1;
	localparam logic [1:0] OUT_REFRESH = 2'd2;
	localparam logic [1:0] OUT_BYPASS = 2'd3;

	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_LIFETIME = 1'b1;

	typedef struct packed {
		logic [23:0] capacity;
		logic [15:0] default_lifetime;
	} cfg_t;

endpackage

// ===== design/ttl_bucket_fifo_cache_policy_top.sv =====
// Top level of the TTL-bucketed FIFO cache policy: APB registers and stream ports.
// Depends on ttlbf_pkg and ttlbf_core (which uses ttlbf_ram).
`timescale 1ns / 1ps
// Usage
// Each request on the s_axis channel names an object (id, size, time, lifetime).
// The block looks it up, refreshes or inserts it into its expiry bucket, and then
// evicts bucket heads, lowest bucket first, until the used size fits the capacity.
// One result per request leaves on m_axis: outcome, evictions and occupancy.
// The APB port holds two registers: capacity at address 0 and default lifetime
// at address 4. Write them only while no request is in flight.
// Timing: a request is handled by one sequencer over shared table RAMs. The key
// scan reads one entry a cycle and stops at the first match; an inserting miss
// scans every entry before any eviction. Each eviction inspects buckets until
// it finds a non-empty one; one request is in work at a time.
// After reset the bucket fill table is cleared, one bucket a cycle; while it is
// cleared s_axis_tready stays low (APB writes still work).
// A finished result waits in an output register; while the receiver stalls
// the next request is still accepted and worked on, and its result waits until
// the register frees up.
module ttl_bucket_fifo_cache_policy_top #(
	parameter int ENTRIES = ttlbf_pkg::ENTRIES_DEF,
	parameter int BUCKETS = ttlbf_pkg::BUCKETS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// object_id[31:0], object_size[47:32], now[79:48], lifetime[95:80]
	input  logic [95:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// outcome[1:0], evicted_count[8:2], occupancy[32:9], zero padding[39:33]
	output logic [39:0] m_axis_tdata
);

	ttlbf_pkg::cfg_t cfg_q;
	logic [1:0]  outcome;
	logic [6:0]  evicted_count;
	logic [23:0] occupancy;

	assign pready = 1'b1;

	// The register index is bit 2 of the byte address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity <= ttlbf_pkg::CAPACITY_RST;
			cfg_q.default_lifetime <= ttlbf_pkg::LIFETIME_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				ttlbf_pkg::REG_CAPACITY: cfg_q.capacity <= pwdata[23:0];
				ttlbf_pkg::REG_LIFETIME: cfg_q.default_lifetime <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ttlbf_pkg::REG_CAPACITY: prdata = {8'd0, cfg_q.capacity};
			ttlbf_pkg::REG_LIFETIME: prdata = {16'd0, cfg_q.default_lifetime};
			default: prdata = '0;
		endcase
	end

	ttlbf_core #(.ENTRIES(ENTRIES), .BUCKETS(BUCKETS)) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.object_id(s_axis_tdata[31:0]),
		.object_size(s_axis_tdata[47:32]),
		.now(s_axis_tdata[79:48]),
		.lifetime(s_axis_tdata[95:80]),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.outcome(outcome),
		.evicted_count(evicted_count),
		.occupancy(occupancy)
	);

	assign m_axis_tdata = {7'd0, occupancy, evicted_count, outcome};

endmodule

// ===== design/ttlbf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used by ttlbf_core for every table; depends on nothing.
`timescale 1ns / 1ps
module ttlbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/ttlbf_core.sv =====
// Sequencer of the TTL-bucketed FIFO cache: lookup scan, relink, insert and eviction.
// Depends on ttlbf_pkg and ttlbf_ram.
`timescale 1ns / 1ps
module ttlbf_core #(
	parameter int ENTRIES = ttlbf_pkg::ENTRIES_DEF,
	parameter int BUCKETS = ttlbf_pkg::BUCKETS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ttlbf_pkg::cfg_t   cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       object_id,
	input  logic [15:0]       object_size,
	input  logic [31:0]       now,
	input  logic [15:0]       lifetime,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        outcome,
	output logic [6:0]        evicted_count,
	output logic [23:0]       occupancy
);

	localparam int EW = $clog2(ENTRIES);
	localparam int BW = $clog2(BUCKETS);
	localparam int FW = $clog2(ENTRIES + 1);
	localparam int UW = EW + 17;
	localparam logic [EW:0] ENT_N = (EW+1)'(ENTRIES);
	localparam logic [EW-1:0] ENT_LAST = EW'(ENTRIES - 1);
	localparam logic [BW-1:0] BKT_LAST = BW'(BUCKETS - 1);
	localparam logic [31:0] BKT_LAST32 = 32'(BUCKETS - 1);

	localparam logic [4:0] ST_CLR  = 5'd0;
	localparam logic [4:0] ST_IDLE = 5'd1;
	localparam logic [4:0] ST_SCAN = 5'd2;
	localparam logic [4:0] ST_FEXP = 5'd3;
	localparam logic [4:0] ST_FCHK = 5'd4;
	localparam logic [4:0] ST_URD  = 5'd5;
	localparam logic [4:0] ST_UWR  = 5'd6;
	localparam logic [4:0] ST_PRD  = 5'd7;
	localparam logic [4:0] ST_PWR  = 5'd8;
	localparam logic [4:0] ST_MISS = 5'd9;
	localparam logic [4:0] ST_INS  = 5'd10;
	localparam logic [4:0] ST_LCHK = 5'd11;
	localparam logic [4:0] ST_EADR = 5'd12;
	localparam logic [4:0] ST_ECHK = 5'd13;
	localparam logic [4:0] ST_EHD  = 5'd14;
	localparam logic [4:0] ST_EDO  = 5'd15;
	localparam logic [4:0] ST_DONE = 5'd16;

	logic [4:0]         st_q;
	logic [BW-1:0]      clr_q;
	logic [31:0]        id_q, now_q, exp_q, epoch_q;
	logic [15:0]        size_q;
	logic               started_q;
	logic [BW-1:0]      evb_q, b_q;
	logic [UW-1:0]      used_q;
	logic [ENTRIES-1:0] valid_q;
	logic [EW-1:0]      slot_q, fidx_q;
	logic               free_q, ev_ins_q;
	logic [EW:0]        cnt_q;
	logic               chk_s1;
	logic [EW-1:0]      ent_s1;
	logic [FW-1:0]      efill_q;
	logic [1:0]         outc_q;
	logic [6:0]         evc_q;

	// RAM read data
	logic [31:0]   key_rd, exp_rd;
	logic [15:0]   bytes_rd;
	logic [EW-1:0] next_rd, prev_rd, head_rd, tail_rd;
	logic [FW-1:0] fill_rd;

	// RAM write controls
	logic          next_we, prev_we, head_we, tail_we, fill_we, exp_we, ins_we;
	logic [EW-1:0] next_wa, next_wd, prev_wa, prev_wd, head_wd, tail_wd;
	logic [BW-1:0] head_wa, fill_wa, bkt_ra;
	logic [FW-1:0] fill_wd;

	// Shared bucket-offset unit: one subtract, two compares and a clamp.
	logic [31:0] bop, bep, bdiff;
	logic [BW-1:0] bkt;
	always_comb begin
		bop = (st_q == ST_FCHK) ? exp_rd : exp_q;
		bep = started_q ? epoch_q : now_q;
		bdiff = (bop >= bep) ? (bop - bep) : 32'd0;
		bkt = (bdiff >= BKT_LAST32) ? BKT_LAST : bdiff[BW-1:0];
	end

	logic        size_ok, expired, hit_now;
	logic [15:0] life_eff;
	logic [32:0] exp_sum;
	logic [31:0] used32;
	logic        out_take;
	always_comb begin
		size_ok = {8'd0, size_q} <= cfg.capacity;
		expired = exp_rd < now_q;
		hit_now = chk_s1 && valid_q[ent_s1] && (key_rd == id_q);
		life_eff = (lifetime == 16'd0) ? cfg.default_lifetime : lifetime;
		exp_sum = {1'b0, now} + {17'd0, life_eff};
		used32 = 32'(used_q);
		out_take = (st_q == ST_DONE) && (!out_valid || out_ready);
	end

	always_comb begin
		next_we = 1'b0; next_wa = prev_rd; next_wd = next_rd;
		prev_we = 1'b0; prev_wa = next_rd; prev_wd = prev_rd;
		head_we = 1'b0; head_wa = b_q;     head_wd = next_rd;
		tail_we = 1'b0; tail_wd = prev_rd;
		fill_we = 1'b0; fill_wa = b_q;     fill_wd = fill_rd - FW'(1);
		exp_we  = (st_q == ST_INS) || (st_q == ST_FCHK && expired);
		ins_we  = (st_q == ST_INS);
		bkt_ra  = (st_q == ST_EADR) ? evb_q : b_q;
		unique case (st_q)
			ST_CLR: begin
				fill_we = 1'b1; fill_wa = clr_q; fill_wd = '0;
			end
			ST_UWR: begin
				if (fill_rd != '0) begin
					fill_we = 1'b1;
					if (fill_rd > FW'(1)) begin
						if (head_rd == slot_q) begin
							head_we = 1'b1;
						end else if (tail_rd == slot_q) begin
							tail_we = 1'b1;
						end else begin
							next_we = 1'b1;
							prev_we = 1'b1;
						end
					end
				end
			end
			ST_PWR: begin
				fill_we = 1'b1; fill_wd = fill_rd + FW'(1);
				tail_we = 1'b1; tail_wd = slot_q;
				if (fill_rd == '0) begin
					head_we = 1'b1; head_wd = slot_q;
				end else begin
					next_we = 1'b1; next_wa = tail_rd; next_wd = slot_q;
					prev_we = 1'b1; prev_wa = slot_q;  prev_wd = tail_rd;
				end
			end
			ST_EDO: begin
				fill_we = 1'b1; fill_wa = evb_q; fill_wd = efill_q - FW'(1);
				head_wa = evb_q;
				head_we = efill_q > FW'(1);
			end
			default: begin
			end
		endcase
	end

	ttlbf_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key (
		.clk(clk), .we(ins_we), .waddr(slot_q), .wdata(id_q),
		.raddr(cnt_q[EW-1:0]), .rdata(key_rd));
	ttlbf_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_bytes (
		.clk(clk), .we(ins_we), .waddr(slot_q), .wdata(size_q),
		.raddr(slot_q), .rdata(bytes_rd));
	ttlbf_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_exp (
		.clk(clk), .we(exp_we), .waddr(slot_q), .wdata(exp_q),
		.raddr(slot_q), .rdata(exp_rd));
	ttlbf_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_next (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(slot_q), .rdata(next_rd));
	ttlbf_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_prev (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(slot_q), .rdata(prev_rd));
	ttlbf_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_head (
		.clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
		.raddr(bkt_ra), .rdata(head_rd));
	ttlbf_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_tail (
		.clk(clk), .we(tail_we), .waddr(b_q), .wdata(tail_wd),
		.raddr(bkt_ra), .rdata(tail_rd));
	ttlbf_ram #(.WIDTH(FW), .DEPTH(BUCKETS)) u_fill (
		.clk(clk), .we(fill_we), .waddr(fill_wa), .wdata(fill_wd),
		.raddr(bkt_ra), .rdata(fill_rd));

	assign in_ready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			started_q <= 1'b0;
			epoch_q <= '0;
			evb_q <= '0;
			used_q <= '0;
			valid_q <= '0;
			chk_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && !out_take) begin
				out_valid <= 1'b0;
			end
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BKT_LAST) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						id_q <= object_id;
						size_q <= object_size;
						now_q <= now;
						exp_q <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
						cnt_q <= '0;
						chk_s1 <= 1'b0;
						free_q <= 1'b0;
						evc_q <= '0;
						st_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					chk_s1 <= cnt_q < ENT_N;
					ent_s1 <= cnt_q[EW-1:0];
					if (cnt_q < ENT_N) begin
						cnt_q <= cnt_q + (EW+1)'(1);
					end
					if (chk_s1 && !valid_q[ent_s1] && !free_q) begin
						free_q <= 1'b1;
						fidx_q <= ent_s1;
					end
					if (hit_now) begin
						slot_q <= ent_s1;
						st_q <= ST_FEXP;
					end else if (chk_s1 && ent_s1 == ENT_LAST) begin
						st_q <= ST_MISS;
					end
				end
				ST_FEXP: st_q <= ST_FCHK;
				ST_FCHK: begin
					if (expired) begin
						outc_q <= ttlbf_pkg::OUT_REFRESH;
						b_q <= bkt;
						st_q <= ST_URD;
					end else begin
						outc_q <= ttlbf_pkg::OUT_HIT;
						st_q <= size_ok ? ST_LCHK : ST_DONE;
					end
				end
				ST_URD: st_q <= ST_UWR;
				ST_UWR: begin
					b_q <= bkt;
					st_q <= ST_PRD;
				end
				ST_PRD: st_q <= ST_PWR;
				ST_PWR: begin
					if (b_q < evb_q) begin
						evb_q <= b_q;
					end
					st_q <= size_ok ? ST_LCHK : ST_DONE;
				end
				ST_MISS: begin
					if (!size_ok) begin
						outc_q <= ttlbf_pkg::OUT_BYPASS;
						st_q <= ST_DONE;
					end else begin
						outc_q <= ttlbf_pkg::OUT_MISS;
						if (free_q) begin
							slot_q <= fidx_q;
							st_q <= ST_INS;
						end else begin
							ev_ins_q <= 1'b1;
							st_q <= ST_EADR;
						end
					end
				end
				ST_INS: begin
					if (!started_q) begin
						started_q <= 1'b1;
						epoch_q <= now_q;
					end
					valid_q[slot_q] <= 1'b1;
					used_q <= used_q + UW'(size_q);
					b_q <= bkt;
					st_q <= ST_PRD;
				end
				ST_LCHK: begin
					if (used32 > {8'd0, cfg.capacity}) begin
						ev_ins_q <= 1'b0;
						st_q <= ST_EADR;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_EADR: st_q <= ST_ECHK;
				ST_ECHK: begin
					if (fill_rd == '0) begin
						if (evb_q == BKT_LAST) begin
							st_q <= ev_ins_q ? ST_LCHK : ST_DONE;
						end else begin
							evb_q <= evb_q + BW'(1);
							st_q <= ST_EADR;
						end
					end else begin
						slot_q <= head_rd;
						efill_q <= fill_rd;
						st_q <= ST_EHD;
					end
				end
				ST_EHD: st_q <= ST_EDO;
				ST_EDO: begin
					valid_q[slot_q] <= 1'b0;
					used_q <= (used_q >= UW'(bytes_rd)) ? used_q - UW'(bytes_rd) : '0;
					if (evc_q != 7'd127) begin
						evc_q <= evc_q + 7'd1;
					end
					st_q <= ev_ins_q ? ST_INS : ST_LCHK;
				end
				ST_DONE: begin
					if (out_take) begin
						out_valid <= 1'b1;
						outcome <= outc_q;
						evicted_count <= evc_q;
						occupancy <= (used32 > 32'h00FF_FFFF) ? 24'hFF_FFFF
							: used32[23:0];
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule
